// ----- rtl/core/sbfd_pkg.sv -----
// Shared types and constants of the stereo box filter decimator.
`default_nettype none
package sbfd_pkg;

  localparam int unsigned MAX_FRAME_INPUTS = 35112;
  localparam logic [15:0] IN_COUNT_RST     = 16'd35112;
  localparam logic [15:0] OUT_COUNT_RST    = 16'd1024;
  localparam logic [15:0] SCALE_DIVISOR    = 16'd4389;
  // 2^44 / 4389 rounded up: the high bits of acc * SCALE_RECIP give acc / 4389
  // exactly for every 32-bit acc
  localparam logic [31:0] SCALE_RECIP      = 32'd4008244713;
  localparam int unsigned SCALE_SHIFT      = 44;
  localparam logic [36:0] SCALE_ROUND      = 37'd8192;
  localparam int unsigned DIV_STEPS        = 32;
  localparam int unsigned DIV_CNT_W        = $clog2(DIV_STEPS + 1);
  localparam int unsigned JOBQ_DEPTH       = 4;
  localparam int unsigned JOBQ_PTR_W       = $clog2(JOBQ_DEPTH);
  localparam int unsigned JOBQ_CNT_W       = $clog2(JOBQ_DEPTH + 1);
  localparam int unsigned QUOT_W           = 20;   // 2^32 / 4389 fits in 20 bits

  typedef enum logic [0:0] {
    CFG_IN_COUNT  = 1'b0,
    CFG_OUT_COUNT = 1'b1
  } cfg_index_t;

  typedef struct packed {
    logic [15:0] left_level;
    logic [15:0] right_level;
  } in_item_t;

  typedef struct packed {
    logic [15:0] right_sample;
    logic [15:0] left_sample;
    logic        last;
  } out_item_t;

  typedef struct packed {
    logic [15:0] in_count;
    logic [15:0] out_count;
  } cfg_t;

  // One finished accumulation waiting to be scaled.
  typedef struct packed {
    logic [31:0] right_acc;
    logic [31:0] left_acc;
    logic        last;
    logic [15:0] out_count;
  } job_t;

endpackage
`default_nettype wire

// ----- rtl/core/stereo_box_filter_decimator.sv -----
// Top level of the stereo box filter decimator.
//
//   channel   direction  handshake                   payload
//   in_       request    in_push / in_full           in_data    (left/right level)
//   out_      result     out_pop / out_empty         out_data   (samples, last)
//   cfg_      write      cfg_we                      cfg_index, cfg_wdata
//
// The first pair of a frame that emits outputs waits on the 16.16 step ratio
// from the serial divider in the front, one quotient bit per cycle. Each output
// is queued, then multiplied by the reciprocal of 4389 (ST_RECIP) and by
// out_count (ST_MUL) and held on out_ (ST_HOLD); the back takes a new sum only
// once its last result has been popped.
// The front stalls (in_full) only while the four-entry job queue is full or the
// ratio divide runs; a result waiting on out_ never stalls the front directly.
// rst_n is synchronous: it empties both ends and restores in_count to 35112 and
// out_count to 1024.
`default_nettype none
module stereo_box_filter_decimator (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_push,
  input  wire sbfd_pkg::in_item_t in_data,
  output logic                in_full,
  output logic                out_empty,
  input  wire logic           out_pop,
  output sbfd_pkg::out_item_t out_data,
  input  wire logic           cfg_we,
  input  wire logic [0:0]     cfg_index,
  input  wire logic [15:0]    cfg_wdata
);
  import sbfd_pkg::*;

  logic [15:0] in_count_r;
  logic [15:0] out_count_r;
  cfg_t        cfg;
  logic        jobq_full, jobq_empty, job_push, jobq_pop;
  job_t        job, head_job;

  // Hold the frame registers; a write lands in the register its index names.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_count_r  <= IN_COUNT_RST;
      out_count_r <= OUT_COUNT_RST;
    end else if (cfg_we) begin
      unique case (cfg_index_t'(cfg_index))
        CFG_IN_COUNT:  in_count_r  <= cfg_wdata;
        CFG_OUT_COUNT: out_count_r <= cfg_wdata;
        default:       in_count_r  <= in_count_r;
      endcase
    end
  end

  assign cfg.in_count  = in_count_r;
  assign cfg.out_count = out_count_r;

  // Front: accept pairs, track the frame, accumulate, queue finished sums.
  sbfd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .jobq_full (jobq_full),
    .job_push  (job_push),
    .job       (job)
  );

  // Decouple the two ends so that each can stall alone.
  sbfd_jobq u_jobq (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (job_push),
    .push_job (job),
    .pop      (jobq_pop),
    .head_job (head_job),
    .full     (jobq_full),
    .empty    (jobq_empty)
  );

  // Back: scale each queued sum and present it as the oldest result.
  sbfd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .jobq_empty (jobq_empty),
    .head_job   (head_job),
    .jobq_pop   (jobq_pop),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_data   (out_data)
  );

endmodule
`default_nettype wire

// ----- rtl/core/sbfd_div.sv -----
// Radix-2 restoring divider, 32-bit dividend by 16-bit divisor, one bit per cycle.
`default_nettype none
module sbfd_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] dividend,
  input  wire logic [15:0] divisor,
  output logic             done,
  output logic [31:0]      quotient
);
  import sbfd_pkg::*;

  logic                 busy_r, busy_nxt;
  logic                 done_r, done_nxt;
  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic [15:0]          rem_r, rem_nxt;
  logic [31:0]          quo_r, quo_nxt;
  logic [15:0]          dsr_r, dsr_nxt;
  logic [16:0]          trial;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    trial    = {rem_r, quo_r[31]};
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = DIV_CNT_W'(DIV_STEPS);
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
    end else if (busy_r) begin
      // shift in the next dividend bit, subtract when the divisor fits
      if (trial >= {1'b0, dsr_r}) begin
        rem_nxt = 16'(trial - {1'b0, dsr_r});
        quo_nxt = {quo_r[30:0], 1'b1};
      end else begin
        rem_nxt = trial[15:0];
        quo_nxt = {quo_r[30:0], 1'b0};
      end
      cnt_nxt = cnt_r - DIV_CNT_W'(1);
      if (cnt_r == DIV_CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule
`default_nettype wire

// ----- rtl/core/sbfd_jobq.sv -----
// Short queue of accumulated outputs between the front and the back.
`default_nettype none
module sbfd_jobq (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire sbfd_pkg::job_t push_job,
  input  wire logic          pop,
  output sbfd_pkg::job_t     head_job,
  output logic               full,
  output logic               empty
);
  import sbfd_pkg::*;

  job_t                  mem_r [JOBQ_DEPTH];
  logic [JOBQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [JOBQ_PTR_W-1:0] rd_r, rd_nxt;
  logic [JOBQ_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                  do_push, do_pop;

  assign full    = (cnt_r == JOBQ_CNT_W'(JOBQ_DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  always_comb begin
    wr_nxt  = do_push ? JOBQ_PTR_W'(wr_r + 1'b1) : wr_r;
    rd_nxt  = do_pop  ? JOBQ_PTR_W'(rd_r + 1'b1) : rd_r;
    cnt_nxt = cnt_r;
    unique case ({do_push, do_pop})
      2'b10:   cnt_nxt = cnt_r + JOBQ_CNT_W'(1);
      2'b01:   cnt_nxt = cnt_r - JOBQ_CNT_W'(1);
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (do_push) begin
      mem_r[wr_r] <= push_job;
    end
  end

  assign head_job = mem_r[rd_r];

endmodule
`default_nettype wire

// ----- rtl/core/sbfd_front.sv -----
// Front end: frame tracking, step ratio, accumulation and output scheduling.
`default_nettype none
module sbfd_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire sbfd_pkg::cfg_t cfg,
  input  wire logic          in_push,
  input  wire sbfd_pkg::in_item_t in_data,
  output logic               in_full,
  input  wire logic          jobq_full,
  output logic               job_push,
  output sbfd_pkg::job_t     job
);
  import sbfd_pkg::*;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_DIV
  } state_t;

  state_t      state_r;
  logic [31:0] step_r, step_nxt;
  logic [15:0] whole_r, whole_nxt;
  logic [15:0] frac_r, frac_nxt;
  logic [31:0] lacc_r, lacc_nxt;
  logic [31:0] racc_r, racc_nxt;
  logic [15:0] taken_r, taken_nxt;
  logic [15:0] made_r, made_nxt;
  in_item_t    hold_r;

  logic [15:0] frame_len, len;
  logic        accept, need_div, go, emit, extra;
  logic        div_done;
  logic [31:0] div_q;
  in_item_t    item;
  logic [31:0] b_step, b_lacc, b_racc, nt, lt, rt, lsh, rsh;
  logic [15:0] b_whole, b_frac, b_made, b_taken;
  logic [16:0] w;

  assign frame_len = (cfg.in_count > 16'(MAX_FRAME_INPUTS)) ?
                     16'(MAX_FRAME_INPUTS) : cfg.in_count;
  assign len       = (frame_len == '0) ? 16'd1 : frame_len;
  assign in_full   = (state_r != ST_IDLE) || jobq_full;
  assign accept    = in_push && !in_full;
  assign need_div  = (taken_r == '0) && (cfg.out_count != '0) &&
                     (frame_len >= cfg.out_count);
  assign go        = (state_r == ST_IDLE) ? (accept && !need_div) : div_done;

  sbfd_div u_ratio_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (accept && need_div),
    .dividend ({frame_len, 16'h0000}),
    .divisor  (cfg.out_count),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    b_step  = step_r;
    b_whole = whole_r;
    b_frac  = frac_r;
    b_lacc  = lacc_r;
    b_racc  = racc_r;
    b_made  = made_r;
    b_taken = taken_r;
    item    = in_data;
    if (state_r == ST_DIV) begin
      // frame start with a valid ratio
      b_step  = div_q;
      b_whole = div_q[31:16];
      b_frac  = div_q[15:0];
      b_lacc  = '0;
      b_racc  = '0;
      b_made  = '0;
      b_taken = '0;
      item    = hold_r;
    end else if (taken_r == '0) begin
      // frame start that emits nothing
      b_step  = '0;
      b_whole = '0;
      b_frac  = '0;
      b_lacc  = '0;
      b_racc  = '0;
      b_made  = '0;
    end

    lsh   = {item.left_level, 16'h0000};
    rsh   = {item.right_level, 16'h0000};
    lt    = {16'h0000, item.left_level} * {16'h0000, b_frac};
    rt    = {16'h0000, item.right_level} * {16'h0000, b_frac};
    nt    = b_step - 32'h0001_0000 + {16'h0000, b_frac};
    emit  = 1'b0;
    extra = 1'b0;

    step_nxt  = b_step;
    whole_nxt = b_whole;
    frac_nxt  = b_frac;
    lacc_nxt  = b_lacc;
    racc_nxt  = b_racc;
    made_nxt  = b_made;
    job.right_acc = b_racc;
    job.left_acc  = b_lacc;

    if ((b_step != '0) && (b_made < cfg.out_count)) begin
      if (b_whole != '0) begin
        lacc_nxt  = b_lacc + lsh;
        racc_nxt  = b_racc + rsh;
        whole_nxt = b_whole - 16'd1;
        job.left_acc  = lacc_nxt;
        job.right_acc = racc_nxt;
        if ((b_whole == 16'd1) && (b_frac == '0)) begin
          emit     = 1'b1;
          extra    = 1'b1;
          lacc_nxt = '0;
          racc_nxt = '0;
        end
      end else begin
        // border pair: split between this output and the next
        emit          = 1'b1;
        job.left_acc  = b_lacc + lt;
        job.right_acc = b_racc + rt;
        lacc_nxt      = lsh - lt;
        racc_nxt      = rsh - rt;
      end
    end

    w = {1'b0, nt[31:16]} + {16'h0000, extra};
    if (emit) begin
      whole_nxt = w[16] ? 16'hFFFF : w[15:0];
      frac_nxt  = nt[15:0];
      made_nxt  = b_made + 16'd1;
    end
    job.last      = (({1'b0, b_made} + 17'd1) == {1'b0, cfg.out_count});
    job.out_count = cfg.out_count;
    job_push      = go && emit;

    taken_nxt = b_taken + 16'd1;
    if ((taken_nxt >= len) || (taken_nxt == '0)) begin
      // frame end: clear everything
      step_nxt  = '0;
      whole_nxt = '0;
      frac_nxt  = '0;
      lacc_nxt  = '0;
      racc_nxt  = '0;
      made_nxt  = '0;
      taken_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      whole_r <= '0;
      frac_r  <= '0;
      lacc_r  <= '0;
      racc_r  <= '0;
      taken_r <= '0;
      made_r  <= '0;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (accept && need_div) begin
            state_r <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
      if (go) begin
        step_r  <= step_nxt;
        whole_r <= whole_nxt;
        frac_r  <= frac_nxt;
        lacc_r  <= lacc_nxt;
        racc_r  <= racc_nxt;
        taken_r <= taken_nxt;
        made_r  <= made_nxt;
      end
    end
    if (accept) begin
      hold_r <= in_data;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/sbfd_back.sv -----
// Back end: scale each accumulation to a 16-bit sample and hold it for the consumer.
`default_nettype none
module sbfd_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           jobq_empty,
  input  wire sbfd_pkg::job_t head_job,
  output logic                jobq_pop,
  output logic                out_empty,
  input  wire logic           out_pop,
  output sbfd_pkg::out_item_t out_data
);
  import sbfd_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RECIP,
    ST_MUL,
    ST_HOLD
  } state_t;

  state_t            state_r;
  logic [15:0]       ocnt_r;
  logic              last_r;
  logic [31:0]       racc_r, lacc_r;
  logic [QUOT_W-1:0] rq_r, lq_r;
  logic [63:0]       rrecip, lrecip;
  logic [35:0]       rprod, lprod;
  logic [36:0]       rsum, lsum;
  out_item_t         res_r;

  assign jobq_pop = (state_r == ST_IDLE) && !jobq_empty;

  // divide by 4389 as a multiply by its rounded-up reciprocal
  assign rrecip = {32'h0000_0000, racc_r} * {32'h0000_0000, SCALE_RECIP};
  assign lrecip = {32'h0000_0000, lacc_r} * {32'h0000_0000, SCALE_RECIP};

  assign rprod = {16'h0000, rq_r} * {20'h00000, ocnt_r};
  assign lprod = {16'h0000, lq_r} * {20'h00000, ocnt_r};
  assign rsum  = {1'b0, rprod} + SCALE_ROUND;
  assign lsum  = {1'b0, lprod} + SCALE_ROUND;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (jobq_pop) begin
            state_r <= ST_RECIP;
          end
        end
        ST_RECIP: begin
          state_r <= ST_MUL;
        end
        ST_MUL: begin
          state_r <= ST_HOLD;
        end
        ST_HOLD: begin
          if (out_pop) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
    if (jobq_pop) begin
      racc_r <= head_job.right_acc;
      lacc_r <= head_job.left_acc;
      ocnt_r <= head_job.out_count;
      last_r <= head_job.last;
    end
    if (state_r == ST_RECIP) begin
      rq_r <= rrecip[SCALE_SHIFT +: QUOT_W];
      lq_r <= lrecip[SCALE_SHIFT +: QUOT_W];
    end
    if (state_r == ST_MUL) begin
      res_r.right_sample <= rsum[29:14];
      res_r.left_sample  <= lsum[29:14];
      res_r.last         <= last_r;
    end
  end

  assign out_empty = (state_r != ST_HOLD);
  assign out_data  = res_r;

endmodule
`default_nettype wire

// ----- rtl/core/sbfd_chk.sv -----
// Port-level checks of the stereo box filter decimator and their binding.
`default_nettype none
module sbfd_chk (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_full,
  input  wire logic           out_empty,
  input  wire logic           out_pop,
  input  wire sbfd_pkg::out_item_t out_data
);
  import sbfd_pkg::*;

  // No result survives a reset.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result pending right after reset");

  // The front comes out of reset ready for a request.
  a_reset_ready: assert property (@(posedge clk) !rst_n |=> !in_full)
    else $error("input blocked right after reset");

  // A result that is not taken stays put.
  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
      (!out_empty && !out_pop) |=> (!out_empty && $stable(out_data)))
    else $error("pending result changed or vanished");

endmodule

bind stereo_box_filter_decimator sbfd_chk u_sbfd_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_full   (in_full),
  .out_empty (out_empty),
  .out_pop   (out_pop),
  .out_data  (out_data)
);
`default_nettype wire
